// ----- rtl/core/gldg_pkg.sv -----
// Shared types, constants and helper functions of the GPU load governor.
package gldg_pkg;

    localparam int LEVEL_W        = 3;
    localparam int NUM_LEVELS     = 5;
    localparam int ACCUM_BITS_DEF = 40;
    localparam int TIME_W         = 32;
    localparam int LOAD_W         = 8;
    localparam int POLL_W         = 20;
    localparam int TABLE_W        = 40;
    localparam int TABLE_ENTRIES  = 5;
    localparam int REQ_W          = 2;
    localparam int MODE_W         = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 40;
    localparam int IN_DATA_W      = 72;
    localparam int OUT_DATA_W     = 16;
    localparam int QBIT_W         = 3;

    localparam logic [POLL_W-1:0]  POLL_MIN     = 20'd10000;
    localparam logic [POLL_W-1:0]  POLL_DEF     = 20'd100000;
    localparam logic [POLL_W-1:0]  POLL_MAX     = 20'd1000000;
    localparam logic [TABLE_W-1:0] UP_DEF       = 40'd430760944238;
    localparam logic [TABLE_W-1:0] DOWN_DEF     = 40'd2960700;
    localparam logic [LEVEL_W-1:0] SLOWEST_DEF  = 3'd4;
    localparam logic [LEVEL_W-1:0] FASTEST_DEF  = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP    = LEVEL_W'(NUM_LEVELS - 1);
    localparam logic [LOAD_W-1:0]  LOAD_SAT     = 8'hFF;
    localparam logic [QBIT_W-1:0]  QBIT_TOP     = 3'd7;

    localparam logic [MODE_W-1:0] MODE_CONSERV = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENERGY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PERF    = 2'd2;

    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SLEEP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WAKE   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLL    = 3'd0,
        CFG_MODE    = 3'd1,
        CFG_UP      = 3'd2,
        CFG_DOWN    = 3'd3,
        CFG_SLOWEST = 3'd4,
        CFG_FASTEST = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_MUL,
        ST_SAT,
        ST_DIV,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              exec;
        logic              mul;
        logic              sat_chk;
        logic              div_step;
        logic [QBIT_W-1:0] div_bit;
        logic              decide;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic eval_go;
        logic sat;
        logic out_free;
    } status_t;

    // Threshold byte of one level; levels past the table read as zero.
    function automatic logic [LOAD_W-1:0] table_byte(input logic [TABLE_W-1:0] tbl,
                                                      input logic [LEVEL_W-1:0] lvl);
        logic [LOAD_W-1:0] b;
        case (lvl)
            3'd0:    b = tbl[7:0];
            3'd1:    b = tbl[15:8];
            3'd2:    b = tbl[23:16];
            3'd3:    b = tbl[31:24];
            3'd4:    b = tbl[39:32];
            default: b = '0;
        endcase
        return b;
    endfunction

    // Clamp a one-step target level into the allowed range.
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W:0] target,
                                                        input logic [LEVEL_W-1:0] lo,
                                                        input logic [LEVEL_W-1:0] hi);
        logic [LEVEL_W:0] t;
        t = target;
        if (t > {1'b0, hi})
            t = {1'b0, hi};
        if (t < {1'b0, lo})
            t = {1'b0, lo};
        return t[LEVEL_W-1:0];
    endfunction

endpackage

// ----- rtl/core/gpu_load_dvfs_governor_core.sv -----
// Top level of the GPU load governor: sequencer and datapath joined together.
//
// The block picks a GPU power level (0 is the fastest clock) from load reports.
// Items arrive on the slave stream: tuser carries the request kind (idle load
// report, sleep or wake) and tdata the wall time, busy time and nap flag. Each
// item yields exactly one result item on the master stream with the active level,
// a level-changed flag, an evaluated flag and the computed load percent.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user is to write them only while no item is in flight, which the block
// does not enforce; each write takes effect at the same clock edge.
// An item is taken only while the sequencer is idle. Without a load evaluation
// the item passes the exec, check and finish states; its result is loaded into
// the output register in the finish state, and the sequencer then returns to
// idle to take the next item. When the accumulated wall time passes the poll
// interval, the load is computed by a saturation check and an eight-step
// restoring division, one quotient bit a cycle; a saturated load skips it.
// The output register holds a finished result while the receiver stalls; the
// sequencer waits only when a second result is ready before the first was taken.
// Reset clears the accumulators, restores the register defaults and sets the
// slowest allowed level.
module gpu_load_dvfs_governor_core
#(
    parameter int ACCUM_BITS = gldg_pkg::ACCUM_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gldg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gldg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: wall_time[31:0], busy[63:32], from_nap[64], zero pad.
    input  logic [gldg_pkg::IN_DATA_W-1:0]      s_tdata,
    // Fields from bit 0: req_type[1:0].
    input  logic [gldg_pkg::REQ_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: level[2:0], level_changed[3], evaluated[4], load_pct[12:5],
    // zero pad.
    output logic [gldg_pkg::OUT_DATA_W-1:0]     m_tdata
);

    gldg_pkg::cmd_t    cmd;
    gldg_pkg::status_t status;

    gldg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gldg_dp #(.ACCUM_BITS(ACCUM_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_req    (s_tuser),
        .in_wall   (s_tdata[31:0]),
        .in_busy   (s_tdata[63:32]),
        .in_nap    (s_tdata[64]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- rtl/core/gldg_ctrl.sv -----
// Sequencer of the GPU load governor: steps one item through update, evaluation and output.
module gldg_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  gldg_pkg::status_t  status,
    output gldg_pkg::cmd_t     cmd
);

    gldg_pkg::state_t                 state_reg, state_next;
    logic [gldg_pkg::QBIT_W-1:0]      bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gldg_pkg::ST_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        case (state_reg)
            gldg_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = gldg_pkg::ST_EXEC;
            end
            gldg_pkg::ST_EXEC:
                state_next = gldg_pkg::ST_CHECK;
            gldg_pkg::ST_CHECK:
            begin
                if (status.eval_go)
                    state_next = gldg_pkg::ST_MUL;
                else
                    state_next = gldg_pkg::ST_FINISH;
            end
            gldg_pkg::ST_MUL:
                state_next = gldg_pkg::ST_SAT;
            gldg_pkg::ST_SAT:
            begin
                bit_next = gldg_pkg::QBIT_TOP;
                if (status.sat)
                    state_next = gldg_pkg::ST_DECIDE;
                else
                    state_next = gldg_pkg::ST_DIV;
            end
            gldg_pkg::ST_DIV:
            begin
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                    state_next = gldg_pkg::ST_DECIDE;
            end
            gldg_pkg::ST_DECIDE:
                state_next = gldg_pkg::ST_FINISH;
            gldg_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    state_next = gldg_pkg::ST_IDLE;
            end
            default:
                state_next = gldg_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd         = '0;
        cmd.div_bit = bit_reg;
        s_tready    = 1'b0;
        case (state_reg)
            gldg_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            gldg_pkg::ST_EXEC:   cmd.exec     = 1'b1;
            gldg_pkg::ST_MUL:    cmd.mul      = 1'b1;
            gldg_pkg::ST_SAT:    cmd.sat_chk  = 1'b1;
            gldg_pkg::ST_DIV:    cmd.div_step = 1'b1;
            gldg_pkg::ST_DECIDE: cmd.decide   = 1'b1;
            gldg_pkg::ST_FINISH: cmd.out_load = status.out_free;
            default:             cmd          = '0;
        endcase
    end

endmodule

// ----- rtl/core/gldg_dp.sv -----
// Datapath of the GPU load governor: configuration, accumulators, divider, level and output register.
module gldg_dp
#(
    parameter int ACCUM_BITS = gldg_pkg::ACCUM_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gldg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gldg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [gldg_pkg::REQ_W-1:0]          in_req,
    input  logic [gldg_pkg::TIME_W-1:0]         in_wall,
    input  logic [gldg_pkg::TIME_W-1:0]         in_busy,
    input  logic                                in_nap,
    input  gldg_pkg::cmd_t                      cmd,
    output gldg_pkg::status_t                   status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gldg_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int W = ACCUM_BITS + 8;

    // Configuration.
    logic [gldg_pkg::POLL_W-1:0]   poll_reg;
    logic [gldg_pkg::MODE_W-1:0]   mode_reg;
    logic [gldg_pkg::TABLE_W-1:0]  up_reg;
    logic [gldg_pkg::TABLE_W-1:0]  down_reg;
    logic [gldg_pkg::LEVEL_W-1:0]  slowest_reg;
    logic [gldg_pkg::LEVEL_W-1:0]  fastest_reg;

    // Governor state.
    logic [gldg_pkg::LEVEL_W-1:0]  level_reg;
    logic [ACCUM_BITS-1:0]         wall_acc_reg;
    logic [ACCUM_BITS-1:0]         busy_acc_reg;

    // Current item.
    logic [gldg_pkg::REQ_W-1:0]    req_reg;
    logic [gldg_pkg::TIME_W-1:0]   wall_in_reg;
    logic [gldg_pkg::TIME_W-1:0]   busy_in_reg;
    logic                          nap_reg;
    logic [gldg_pkg::LEVEL_W-1:0]  old_level_reg;
    logic                          rpt_reg;
    logic [W-1:0]                  rem_reg;
    logic                          sat_reg;
    logic [gldg_pkg::LOAD_W-1:0]   q_reg;
    logic                          eval_reg;
    logic [gldg_pkg::LOAD_W-1:0]   load_reg;

    // Output register.
    logic                          out_valid_reg;
    logic [gldg_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [gldg_pkg::LEVEL_W-1:0]  slow_lim;
    logic [gldg_pkg::LEVEL_W-1:0]  fast_lim;
    logic                          pinned;
    logic [ACCUM_BITS:0]           wall_sum;
    logic [ACCUM_BITS:0]           busy_sum;
    logic [W-1:0]                  busy_x100;
    logic [W-1:0]                  wall_shl8;
    logic [W-1:0]                  div_sub;
    logic [W:0]                    div_diff;
    logic [gldg_pkg::LOAD_W-1:0]   load_val;
    logic [gldg_pkg::POLL_W-1:0]   poll_wr;

    assign slow_lim = (slowest_reg > gldg_pkg::LEVEL_TOP) ? gldg_pkg::LEVEL_TOP : slowest_reg;
    assign fast_lim = (fastest_reg < slow_lim) ? fastest_reg : slow_lim;
    assign pinned   = (mode_reg == gldg_pkg::MODE_ENERGY) || (mode_reg == gldg_pkg::MODE_PERF);

    assign wall_sum = {1'b0, wall_acc_reg} + (ACCUM_BITS+1)'(wall_in_reg);
    assign busy_sum = {1'b0, busy_acc_reg} + (ACCUM_BITS+1)'(busy_in_reg);

    // 100 * busy = 64b + 32b + 4b.
    assign busy_x100 = (W'(busy_acc_reg) << 6) + (W'(busy_acc_reg) << 5)
                     + (W'(busy_acc_reg) << 2);
    assign wall_shl8 = {wall_acc_reg, 8'd0};
    assign div_sub   = W'(wall_acc_reg) << cmd.div_bit;
    assign div_diff  = {1'b0, rem_reg} - {1'b0, div_sub};
    assign load_val  = sat_reg ? gldg_pkg::LOAD_SAT : q_reg;

    always_comb
    begin
        poll_wr = cfg_data[gldg_pkg::POLL_W-1:0];
        if (poll_wr < gldg_pkg::POLL_MIN)
            poll_wr = gldg_pkg::POLL_MIN;
        if (poll_wr > gldg_pkg::POLL_MAX)
            poll_wr = gldg_pkg::POLL_MAX;
    end

    assign status.eval_go  = rpt_reg && (wall_acc_reg > ACCUM_BITS'(poll_reg));
    assign status.sat      = (rem_reg >= wall_shl8);
    assign status.out_free = !out_valid_reg || m_tready;

    // Control state: configuration, level and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg     <= gldg_pkg::POLL_DEF;
            mode_reg     <= gldg_pkg::MODE_CONSERV;
            up_reg       <= gldg_pkg::UP_DEF;
            down_reg     <= gldg_pkg::DOWN_DEF;
            slowest_reg  <= gldg_pkg::SLOWEST_DEF;
            fastest_reg  <= gldg_pkg::FASTEST_DEF;
            level_reg    <= (gldg_pkg::SLOWEST_DEF > gldg_pkg::LEVEL_TOP) ?
                            gldg_pkg::LEVEL_TOP : gldg_pkg::SLOWEST_DEF;
            wall_acc_reg <= '0;
            busy_acc_reg <= '0;
            rpt_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gldg_pkg::CFG_POLL:
                        poll_reg <= poll_wr;
                    gldg_pkg::CFG_MODE:
                    begin
                        mode_reg <= cfg_data[gldg_pkg::MODE_W-1:0];
                        if (cfg_data[gldg_pkg::MODE_W-1:0] == gldg_pkg::MODE_ENERGY)
                            level_reg <= slow_lim;
                        else if (cfg_data[gldg_pkg::MODE_W-1:0] == gldg_pkg::MODE_PERF)
                            level_reg <= fast_lim;
                    end
                    gldg_pkg::CFG_UP:      up_reg      <= cfg_data[gldg_pkg::TABLE_W-1:0];
                    gldg_pkg::CFG_DOWN:    down_reg    <= cfg_data[gldg_pkg::TABLE_W-1:0];
                    gldg_pkg::CFG_SLOWEST: slowest_reg <= cfg_data[gldg_pkg::LEVEL_W-1:0];
                    gldg_pkg::CFG_FASTEST: fastest_reg <= cfg_data[gldg_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.exec)
            begin
                rpt_reg <= 1'b0;
                case (req_reg)
                    gldg_pkg::REQ_REPORT:
                    begin
                        if ((wall_in_reg != '0) && !pinned)
                        begin
                            rpt_reg      <= 1'b1;
                            wall_acc_reg <= wall_sum[ACCUM_BITS] ? '1 :
                                            wall_sum[ACCUM_BITS-1:0];
                            busy_acc_reg <= busy_sum[ACCUM_BITS] ? '1 :
                                            busy_sum[ACCUM_BITS-1:0];
                        end
                    end
                    gldg_pkg::REQ_SLEEP:
                    begin
                        if (mode_reg != gldg_pkg::MODE_PERF)
                            level_reg <= slow_lim;
                    end
                    gldg_pkg::REQ_WAKE:
                    begin
                        if (!nap_reg && !pinned)
                        begin
                            wall_acc_reg <= '0;
                            busy_acc_reg <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.decide)
            begin
                wall_acc_reg <= '0;
                busy_acc_reg <= '0;
                if (load_val < gldg_pkg::table_byte(down_reg, level_reg))
                    level_reg <= gldg_pkg::clamp_level({1'b0, level_reg} + 1'b1,
                                                       fast_lim, slow_lim);
                else if (load_val > gldg_pkg::table_byte(up_reg, level_reg))
                    level_reg <= (level_reg == '0) ? fast_lim :
                                 gldg_pkg::clamp_level({1'b0, level_reg} - 1'b1,
                                                       fast_lim, slow_lim);
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg       <= in_req;
            wall_in_reg   <= in_wall;
            busy_in_reg   <= in_busy;
            nap_reg       <= in_nap;
            old_level_reg <= level_reg;
            eval_reg      <= 1'b0;
            load_reg      <= '0;
        end
        if (cmd.mul)
            rem_reg <= busy_x100;
        if (cmd.sat_chk)
        begin
            sat_reg <= status.sat;
            q_reg   <= '0;
        end
        if (cmd.div_step && !div_diff[W])
        begin
            rem_reg             <= div_diff[W-1:0];
            q_reg[cmd.div_bit]  <= 1'b1;
        end
        if (cmd.decide)
        begin
            eval_reg <= 1'b1;
            load_reg <= load_val;
        end
        if (cmd.out_load)
            out_data_reg <= {3'd0, load_reg, eval_reg, (level_reg != old_level_reg),
                             level_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- rtl/core/gldg_checker.sv -----
// Port-level assertions of the GPU load governor and their bind to the top level.
module gldg_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gldg_pkg::OUT_DATA_W-1:0]   m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // One item at a time: no new item the cycle after one is taken.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after acceptance");

    // A fresh result does not appear while the accepted item is in its exec and check states.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!$rose(m_tvalid) ##1 !$rose(m_tvalid)))
        else $error("result appeared too early");

    // Without an evaluation the load field reads zero.
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[4]) |-> (m_tdata[12:5] == '0))
        else $error("load reported without evaluation");

endmodule

bind gpu_load_dvfs_governor_core gldg_checker u_gldg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/testbench.sv -----
// Self-checking testbench of the GPU load governor core: stream stimulus and level prediction.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gldg_pkg::*;

    // Codes that the package leaves unnamed: the undefined mode and the unknown request.
    localparam logic [MODE_W-1:0] MODE_UNDEF  = 2'd3;
    localparam logic [REQ_W-1:0]  REQ_UNKNOWN = 2'd3;

    // Settling time after the inputs go quiet, long enough for a result that is
    // still pending to come out, so that it covers any evaluation in flight.
    localparam int SETTLE_CYCLES = 30;
    // The long receiver stall that backs the block up into its input.
    localparam int HOLD_CYCLES   = 200;
    localparam int NUM_PHASES    = 24;
    localparam int PHASE_ITEMS   = 40;
    localparam int FLOOD_ITEMS   = 330;
    localparam int FLOOD_FILL    = 300;
    // The slowest correct run is well under 100 us; this is more than ten times that.
    localparam int TIMEOUT_NS    = 1_000_000;

    // One result item as it sits in m_tdata, the level in the lowest bits.
    typedef struct packed {
        logic [2:0]         spare;
        logic [LOAD_W-1:0]  load_pct;
        logic               evaluated;
        logic               level_changed;
        logic [LEVEL_W-1:0] level;
    } gov_result_t;

    // The scoreboard keeps its own copy of the governor: registers, active level
    // and the two accumulators. Every accepted item is run through it, and the
    // outcome waits in a queue until the matching result item comes out.
    class level_scoreboard;
        logic [POLL_W-1:0]         poll;
        logic [MODE_W-1:0]         mode;
        logic [TABLE_W-1:0]        up_tbl;
        logic [TABLE_W-1:0]        down_tbl;
        logic [LEVEL_W-1:0]        slowest;
        logic [LEVEL_W-1:0]        fastest;
        logic [LEVEL_W-1:0]        level;
        logic [ACCUM_BITS_DEF-1:0] wall_acc;
        logic [ACCUM_BITS_DEF-1:0] busy_acc;
        gov_result_t               predicted_results[$];
        int                        errors;

        function new();
            poll     = POLL_DEF;
            mode     = MODE_CONSERV;
            up_tbl   = UP_DEF;
            down_tbl = DOWN_DEF;
            slowest  = SLOWEST_DEF;
            fastest  = FASTEST_DEF;
            level    = slow_lim();
            wall_acc = '0;
            busy_acc = '0;
            errors   = 0;
        endfunction

        function logic [LEVEL_W-1:0] slow_lim();
            return (slowest > LEVEL_TOP) ? LEVEL_TOP : slowest;
        endfunction

        function logic [LEVEL_W-1:0] fast_lim();
            logic [LEVEL_W-1:0] s;
            s = slow_lim();
            return (fastest < s) ? fastest : s;
        endfunction

        function logic [LEVEL_W-1:0] step_level(int target);
            int lo;
            int hi;
            lo = int'(fast_lim());
            hi = int'(slow_lim());
            if (target > hi)
                target = hi;
            if (target < lo)
                target = lo;
            return LEVEL_W'(target);
        endfunction

        function logic [LOAD_W-1:0] threshold(logic [TABLE_W-1:0] tbl, logic [LEVEL_W-1:0] lvl);
            if (lvl >= TABLE_ENTRIES)
                return '0;
            return LOAD_W'(tbl >> (8 * lvl));
        endfunction

        function logic [ACCUM_BITS_DEF-1:0] acc_add(logic [ACCUM_BITS_DEF-1:0] a,
                                                   logic [TIME_W-1:0] b);
            logic [63:0] s;
            logic [63:0] top;
            top = (64'd1 << ACCUM_BITS_DEF) - 64'd1;
            s   = 64'(a) + 64'(b);
            return ACCUM_BITS_DEF'((s > top) ? top : s);
        endfunction

        function bit pinned();
            return (mode == MODE_ENERGY) || (mode == MODE_PERF);
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            logic [POLL_W-1:0] p;
            case (idx)
                CFG_POLL: begin
                    p = val[POLL_W-1:0];
                    if (p < POLL_MIN)
                        p = POLL_MIN;
                    if (p > POLL_MAX)
                        p = POLL_MAX;
                    poll = p;
                end
                CFG_MODE: begin
                    mode = val[MODE_W-1:0];
                    if (mode == MODE_ENERGY)
                        level = slow_lim();
                    else if (mode == MODE_PERF)
                        level = fast_lim();
                end
                CFG_UP:      up_tbl   = val[TABLE_W-1:0];
                CFG_DOWN:    down_tbl = val[TABLE_W-1:0];
                CFG_SLOWEST: slowest  = val[LEVEL_W-1:0];
                CFG_FASTEST: fastest  = val[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_level(logic [REQ_W-1:0] req, logic [TIME_W-1:0] wall,
                                    logic [TIME_W-1:0] busy, logic nap);
            gov_result_t        r;
            logic [LEVEL_W-1:0] old;
            logic [63:0]        q;
            old = level;
            r   = '0;
            case (req)
                REQ_REPORT: begin
                    if (wall != '0 && !pinned()) begin
                        wall_acc = acc_add(wall_acc, wall);
                        busy_acc = acc_add(busy_acc, busy);
                        if (wall_acc > poll) begin
                            q = (64'd100 * 64'(busy_acc)) / 64'(wall_acc);
                            r.load_pct  = (q > 64'd255) ? LOAD_SAT : q[LOAD_W-1:0];
                            r.evaluated = 1'b1;
                            wall_acc    = '0;
                            busy_acc    = '0;
                            if (r.load_pct < threshold(down_tbl, level))
                                level = step_level(int'(level) + 1);
                            else if (r.load_pct > threshold(up_tbl, level))
                                level = step_level(int'(level) - 1);
                        end
                    end
                end
                REQ_SLEEP: begin
                    if (mode != MODE_PERF)
                        level = slow_lim();
                end
                REQ_WAKE: begin
                    // Only a wake from full sleep restarts the measurement window.
                    if (!nap && !pinned()) begin
                        wall_acc = '0;
                        busy_acc = '0;
                    end
                end
                default: ;
            endcase
            r.level         = level;
            r.level_changed = (level != old);
            predicted_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            gov_result_t got;
            gov_result_t want;
            got = data;
            if (predicted_results.size() == 0) begin
                $error("result item 0x%h arrived with no prediction waiting", data);
                errors++;
                return;
            end
            want = predicted_results.pop_front();
            if (got.level != want.level) begin
                $error("level: expected %0d, got %0d", want.level, got.level);
                errors++;
            end
            if (got.level_changed != want.level_changed) begin
                $error("level_changed: expected %0d, got %0d",
                       want.level_changed, got.level_changed);
                errors++;
            end
            if (got.evaluated != want.evaluated) begin
                $error("evaluated: expected %0d, got %0d", want.evaluated, got.evaluated);
                errors++;
            end
            if (got.load_pct != want.load_pct) begin
                $error("load_pct: expected %0d, got %0d", want.load_pct, got.load_pct);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic [REQ_W-1:0]        s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;

    level_scoreboard sb = new();

    // Stretches without gaps on either side, and the request for one long stall.
    bit tx_calm;
    bit rx_calm;
    bit rx_hold_req;

    always #1 clk = ~clk;

    gpu_load_dvfs_governor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Offer one item after a random gap and hold it until the block takes it.
    // With no gap, s_tvalid simply stays high from the previous item.
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] wall,
                             input logic [TIME_W-1:0] busy, input logic nap);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= IN_DATA_W'({nap, busy, wall});
        do
            @(posedge clk);
        while (!s_tready);
        sb.predict_level(req, wall, busy, nap);
    endtask

    // Stop offering items and wait until every predicted result has come out.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One register write; the block and the scoreboard both take it at the rising edge.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // A threshold table: all zeros, all ones, the default, fully random, or
    // random bytes in a band around the usual thresholds.
    function automatic logic [TABLE_W-1:0] pick_table(input logic [TABLE_W-1:0] dflt,
                                                      input int lo, input int hi);
        logic [TABLE_W-1:0] t;
        t = '0;
        case ($urandom_range(0, 4))
            0: t = '0;
            1: t = '1;
            2: t = dflt;
            3: t = {8'($urandom), 32'($urandom)};
            default: begin
                for (int k = 0; k < TABLE_ENTRIES; k++)
                    t[8*k +: 8] = 8'($urandom_range(lo, hi));
            end
        endcase
        return t;
    endfunction

    // The receiver takes result items after a random gap of its own and checks each
    // against the oldest prediction. On request it stalls for a long stretch so that
    // the output register and the sequencer fill up and s_tready drops.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold_req) begin
                gap         = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                gap = rx_calm ? 0 : $urandom_range(0, 3);
            end
            repeat (gap) begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin : stimulus
        logic [REQ_W-1:0]    req;
        logic [TIME_W-1:0]   wall;
        logic [TIME_W-1:0]   busy;
        logic [33:0]         busy_cap;
        logic                nap;
        logic [POLL_W-1:0]   poll_val;
        logic [MODE_W-1:0]   mode_val;
        logic [LEVEL_W-1:0]  slow_val;
        logic [LEVEL_W-1:0]  fast_val;
        bit                  flood;
        int                  n_items;
        int                  roll;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_REPORT;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings. A zero wall time does nothing.
        send_item(REQ_REPORT, 32'd0, 32'hFFFF_FFFF, 1'b0);
        // Full-range reports: one evaluation each, at 100 and at 0 percent.
        send_item(REQ_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_REPORT, 32'hFFFF_FFFF, 32'd0, 1'b0);
        // Busy far above wall saturates the load at 255 and climbs toward level 0.
        repeat (5) send_item(REQ_REPORT, 32'd200000, 32'hFFFF_FFFF, 1'b0);
        // Half a window, then a wake from full sleep throws it away.
        send_item(REQ_REPORT, 32'd60000, 32'd30000, 1'b0);
        send_item(REQ_WAKE, 32'd0, 32'd0, 1'b0);
        send_item(REQ_REPORT, 32'd60000, 32'd60000, 1'b0);
        // A wake from nap keeps the window, so the next report evaluates.
        send_item(REQ_WAKE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_REPORT, 32'd50000, 32'd50000, 1'b0);
        // Exactly the poll interval does not evaluate; one more microsecond does.
        send_item(REQ_REPORT, 32'd100000, 32'd0, 1'b0);
        send_item(REQ_REPORT, 32'd1, 32'd0, 1'b0);
        // Sleep drops to the slowest level; an unknown request changes nothing.
        send_item(REQ_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_UNKNOWN, 32'd0, 32'd0, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Registers change only while the block is idle.
            drain_results();
            repeat (SETTLE_CYCLES) @(negedge clk);

            // A flood phase drives the busy accumulator into saturation with many
            // tiny windows of near-full busy time under the longest poll interval.
            flood = (phase % 10 == 5);

            case ($urandom_range(0, 5))
                0: poll_val = '0;
                1: poll_val = '1;
                2: poll_val = POLL_MIN;
                3: poll_val = POLL_MAX;
                4: poll_val = POLL_W'($urandom);
                default: poll_val = POLL_W'($urandom_range(10000, 120000));
            endcase
            if (flood)
                poll_val = '1;

            case (phase % 6)
                1: mode_val = MODE_ENERGY;
                2: mode_val = MODE_PERF;
                4: mode_val = MODE_UNDEF;
                default: mode_val = MODE_CONSERV;
            endcase

            case (phase)
                0: begin
                    slow_val = 3'd7;
                    fast_val = 3'd0;
                end
                6: begin
                    slow_val = 3'd0;
                    fast_val = 3'd7;
                end
                9: begin
                    slow_val = 3'd4;
                    fast_val = 3'd4;
                end
                default: begin
                    slow_val = LEVEL_W'($urandom_range(0, 7));
                    fast_val = LEVEL_W'($urandom_range(0, 7));
                end
            endcase

            write_reg(CFG_POLL, CFG_DATA_W'(poll_val));
            write_reg(CFG_UP, flood ? UP_DEF : pick_table(UP_DEF, 40, 200));
            write_reg(CFG_DOWN, flood ? DOWN_DEF : pick_table(DOWN_DEF, 0, 100));
            write_reg(CFG_SLOWEST, CFG_DATA_W'(slow_val));
            write_reg(CFG_FASTEST, CFG_DATA_W'(fast_val));
            // The mode goes last so that a pinned mode uses the new level limits.
            write_reg(CFG_MODE, CFG_DATA_W'(mode_val));
            @(negedge clk);
            cfg_we <= 1'b0;

            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (phase == 3 || phase == 14)
                rx_hold_req = 1'b1;

            n_items = flood ? FLOOD_ITEMS : PHASE_ITEMS;
            for (int i = 0; i < n_items; i++) begin
                // Once, the sender pauses in the middle of a stream until the
                // block has handed out everything.
                if (phase == 8 && i == 20)
                    drain_results();

                nap  = 1'($urandom_range(0, 1));
                wall = $urandom;
                busy = $urandom;
                roll = $urandom_range(0, 99);
                if (flood) begin
                    req = REQ_REPORT;
                    if (i < FLOOD_FILL) begin
                        wall = $urandom_range(1, 8);
                        busy = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
                    end else begin
                        wall = $urandom_range(1, 2000000);
                    end
                end else if (roll < 78) begin
                    req = REQ_REPORT;
                    case ($urandom_range(0, 19))
                        0: wall = '0;
                        1, 2: wall = $urandom;
                        default: wall = $urandom_range(1, sb.poll / 3 + 1);
                    endcase
                    busy_cap = 34'(wall) * 34'd3;
                    if (busy_cap > 34'hFFFF_FFFF)
                        busy_cap = 34'hFFFF_FFFF;
                    case ($urandom_range(0, 9))
                        0: busy = '0;
                        1: busy = wall;
                        2: busy = $urandom;
                        3, 4: busy = $urandom_range(0, busy_cap[31:0]);
                        default: busy = $urandom_range(0, wall);
                    endcase
                end else if (roll < 86) begin
                    req = REQ_SLEEP;
                end else if (roll < 95) begin
                    req = REQ_WAKE;
                end else begin
                    req = REQ_UNKNOWN;
                end
                send_item(req, wall, busy, nap);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[gpu_load_dvfs_governor_core] OK");
        else
            $display("[gpu_load_dvfs_governor_core] ERROR");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[gpu_load_dvfs_governor_core] ERROR");
        $finish;
    end

endmodule

// ----- gpu_load_dvfs_governor_core.f -----
rtl/core/gldg_pkg.sv
rtl/core/gldg_ctrl.sv
rtl/core/gldg_dp.sv
rtl/core/gpu_load_dvfs_governor_core.sv
rtl/core/gldg_checker.sv
sim/testbench.sv
